@@ rtl/core/mlp_pkg.sv @@
package mlp_pkg;

  localparam int MAX_NODES_DEF    = 16;
  localparam int MAX_MATRICES_DEF = 4;
  localparam int VALUE_WIDTH      = 16;
  localparam int FRAC_BITS        = 12;
  localparam int ACC_WIDTH        = 40;
  localparam int PROD_WIDTH       = 2 * VALUE_WIDTH;
  localparam int MAX_RESULTS      = 16;
  localparam int COUNT_W          = 5;
  localparam int CFG_IDX_W        = 8;
  localparam int CFG_DATA_W       = 8;

  localparam logic [1:0] MODE_WEIGHT = 2'd0;
  localparam logic [1:0] MODE_BIAS   = 2'd1;
  localparam logic [1:0] MODE_SAMPLE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ACT_KIND  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_COUNT  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_CNT  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIDDEN    = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_COUNT = 8'd4;

  typedef enum logic [1:0] {
    ACT_SIGMOID = 2'd0,
    ACT_TANH    = 2'd1,
    ACT_RELU    = 2'd2,
    ACT_LEAKY   = 2'd3
  } act_kind_t;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  // sigmoid(k/2) in Q12 for k = 0..16
  function automatic logic [12:0] sig_lut(input logic [4:0] idx);
    logic [12:0] t;
    unique case (idx)
      5'd0:    t = 13'd2048;
      5'd1:    t = 13'd2550;
      5'd2:    t = 13'd2994;
      5'd3:    t = 13'd3349;
      5'd4:    t = 13'd3608;
      5'd5:    t = 13'd3785;
      5'd6:    t = 13'd3902;
      5'd7:    t = 13'd3976;
      5'd8:    t = 13'd4022;
      5'd9:    t = 13'd4051;
      5'd10:   t = 13'd4069;
      5'd11:   t = 13'd4079;
      5'd12:   t = 13'd4086;
      5'd13:   t = 13'd4090;
      5'd14:   t = 13'd4092;
      5'd15:   t = 13'd4094;
      default: t = 13'd4095;
    endcase
    return t;
  endfunction

endpackage

@@ rtl/core/mlp_if.sv @@
interface mlp_in_if import mlp_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [1:0]  layer;
  logic [3:0]  row;
  logic [3:0]  column;
  value_t      value;
  logic        last;

  modport source (output valid, mode, layer, row, column, value, last, input ready);
  modport sink   (input valid, mode, layer, row, column, value, last, output ready);
endinterface

interface mlp_out_if import mlp_pkg::*; ();
  logic        valid;
  logic        ready;
  value_t      result_value;
  logic [3:0]  result_index;
  logic        result_last;

  modport source (output valid, result_value, result_index, result_last, input ready);
  modport sink   (input valid, result_value, result_index, result_last, output ready);
endinterface

interface mlp_cfg_if import mlp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/mlp_ram.sv @@
module mlp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

@@ rtl/core/mlp_act.sv @@
module mlp_act import mlp_pkg::*; (
  input  logic      clk,
  input  logic      en,
  input  act_kind_t kind,
  input  value_t    x,
  output value_t    y_r
);

  logic signed [16:0] xe;
  logic [16:0]        mag;
  logic [17:0]        arg;
  logic [6:0]         seg;
  logic [10:0]        frac;
  logic [12:0]        t0;
  logic [12:0]        t1;
  logic [8:0]         dlt;
  logic [19:0]        ip;
  logic [12:0]        s;
  logic signed [14:0] tv;
  logic signed [22:0] lk;
  value_t             y_nxt;

  always_comb begin
    xe   = 17'(x);
    mag  = x[VALUE_WIDTH-1] ? 17'(-xe) : 17'(xe);
    // tanh(x) = 2*sigmoid(2x) - 1
    arg  = (kind == ACT_TANH) ? {mag, 1'b0} : {1'b0, mag};
    seg  = arg[17:11];
    frac = arg[10:0];
    t0   = sig_lut(seg[4:0]);
    t1   = sig_lut(5'(seg[4:0] + 5'd1));
    dlt  = 9'(t1 - t0);
    ip   = 20'(dlt) * 20'(frac);
    s    = (seg >= 7'd16) ? sig_lut(5'd16) : 13'(t0 + 13'(ip >> 11));
    tv   = $signed({1'b0, s, 1'b0}) - 15'sd4096;
    lk   = 23'(x) * 23'sd41;
    unique case (kind)
      ACT_SIGMOID: y_nxt = x[VALUE_WIDTH-1] ? value_t'(16'd4096 - 16'(s)) : value_t'(s);
      ACT_TANH:    y_nxt = x[VALUE_WIDTH-1] ? value_t'(-tv) : value_t'(tv);
      ACT_RELU:    y_nxt = x[VALUE_WIDTH-1] ? '0 : x;
      ACT_LEAKY:   y_nxt = (x > 0) ? x : value_t'(lk >>> FRAC_BITS);
      default:     y_nxt = x;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_r <= y_nxt;
    end
  end

endmodule

@@ rtl/core/mlp_forward_inference.sv @@
// Forward pass of a fully connected network, one multiply-accumulate at a time (S_MUL, S_ACC).
// Weight, bias and plain sample words are written straight to their RAMs while idle.
// A sample's last word starts the pass: each output row of a matrix runs S_ROW, S_BIAS
// (bias read), an S_MUL/S_ACC loop over the weight RAM, S_RND (round), S_ACT (activate) and
// S_WB (write back); rows of the last matrix hand their results to out_bus in S_WB.
// rst_n is synchronous, active low: it clears control and config; the RAMs are not cleared.
module mlp_forward_inference import mlp_pkg::*; #(
  parameter int MAX_NODES    = MAX_NODES_DEF,
  parameter int MAX_MATRICES = MAX_MATRICES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  mlp_in_if.sink    in_bus,
  mlp_out_if.source out_bus,
  mlp_cfg_if.sink   cfg_bus
);

  localparam int NW     = $clog2(MAX_NODES);
  localparam int MW     = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
  localparam int CW     = $clog2(MAX_NODES + 1);
  localparam int WDEPTH = MAX_MATRICES * MAX_NODES * MAX_NODES;
  localparam int BDEPTH = MAX_MATRICES * MAX_NODES;
  localparam int VDEPTH = 3 * MAX_NODES;
  localparam int WAW    = $clog2(WDEPTH);
  localparam int BAW    = $clog2(BDEPTH);
  localparam int VAW    = $clog2(VDEPTH);
  localparam int OUTN   = (MAX_NODES < MAX_RESULTS) ? MAX_NODES : MAX_RESULTS;

  typedef enum logic [2:0] {
    S_IDLE, S_ROW, S_BIAS, S_MUL, S_ACC, S_RND, S_ACT, S_WB
  } state_t;

  // config registers
  act_kind_t          act_kind_r;
  logic [COUNT_W-1:0] in_cnt_r;
  logic [COUNT_W-1:0] node_cnt_r;
  logic [1:0]         hid_r;
  logic [COUNT_W-1:0] out_cnt_r;

  state_t                   state_r, state_nxt;
  logic [MW-1:0]            m_r, m_nxt;
  logic [NW-1:0]            r_r, r_nxt;
  logic [NW-1:0]            c_r, c_nxt;
  logic [CW-1:0]            cur_len_r, cur_len_nxt;
  logic signed [ACC_WIDTH-1:0]  acc_r, acc_nxt;
  logic signed [PROD_WIDTH-1:0] prod_r, prod_nxt;
  value_t                   sat_r, sat_nxt;
  logic                     out_valid_r, out_valid_nxt;
  value_t                   out_value_r, out_value_nxt;
  logic [3:0]               out_index_r, out_index_nxt;
  logic                     out_last_r, out_last_nxt;

  logic [CW-1:0] n_in, n_node, n_out, len;
  logic [MW-1:0] last_m;
  logic          last_mat;
  logic          in_ready, in_acc;

  logic                   w_we, b_we, v_we;
  logic [WAW-1:0]         w_waddr, w_raddr;
  logic [BAW-1:0]         b_waddr, b_raddr;
  logic [VAW-1:0]         v_waddr, v_raddr;
  value_t                 v_wdata;
  logic [VALUE_WIDTH-1:0] w_rd, b_rd, v_rd;
  value_t                 act_y;
  logic                   act_en;
  int                     src_reg, dst_reg;

  function automatic logic [CW-1:0] clamp_cnt(input logic [COUNT_W-1:0] v, input int hi);
    if (v == '0) return CW'(1);
    if (int'(v) > hi) return CW'(hi);
    return CW'(v);
  endfunction

  // round Q24 accumulator to Q12 to nearest (ties up), saturate to the value width
  function automatic value_t round_sat(input logic signed [ACC_WIDTH-1:0] a);
    logic signed [ACC_WIDTH-1:0] rs;
    logic signed [ACC_WIDTH-1:0] sh;
    rs = a + ACC_WIDTH'(2048);
    sh = rs >>> FRAC_BITS;
    if (sh > ACC_WIDTH'(32767)) return value_t'(16'sh7fff);
    if (sh < -ACC_WIDTH'(32768)) return value_t'(16'sh8000);
    return value_t'(sh);
  endfunction

  // config: taken whenever offered; the block is idle by contract
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_kind_r <= ACT_SIGMOID;
      in_cnt_r   <= COUNT_W'(16);
      node_cnt_r <= COUNT_W'(16);
      hid_r      <= 2'd1;
      out_cnt_r  <= COUNT_W'(16);
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        REG_ACT_KIND:  act_kind_r <= act_kind_t'(cfg_bus.data[1:0]);
        REG_IN_COUNT:  in_cnt_r   <= cfg_bus.data[COUNT_W-1:0];
        REG_NODE_CNT:  node_cnt_r <= cfg_bus.data[COUNT_W-1:0];
        REG_HIDDEN:    hid_r      <= cfg_bus.data[1:0];
        REG_OUT_COUNT: out_cnt_r  <= cfg_bus.data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes, clamped into the supported range
  always_comb begin
    n_in   = clamp_cnt(in_cnt_r, MAX_NODES);
    n_node = clamp_cnt(node_cnt_r, MAX_NODES);
    n_out  = clamp_cnt(out_cnt_r, OUTN);
    if (hid_r == 2'd0) begin
      last_m = MW'(1);
    end else if (int'(hid_r) > MAX_MATRICES - 1) begin
      last_m = MW'(MAX_MATRICES - 1);
    end else begin
      last_m = MW'(hid_r);
    end
    last_mat = (m_r == last_m);
    len      = last_mat ? n_out : n_node;
  end

  assign in_ready     = (state_r == S_IDLE);
  assign in_bus.ready = in_ready;
  assign in_acc       = in_bus.valid && in_ready;

  // vector RAM holds three regions: sample, then two ping-pong layer vectors
  always_comb begin
    src_reg = (m_r == '0) ? 0 : 1 + ((int'(m_r) - 1) & 1);
    dst_reg = 1 + (int'(m_r) & 1);
  end

  // weight and bias RAM writes from input words
  always_comb begin
    w_we    = in_acc && (in_bus.mode == MODE_WEIGHT) && (int'(in_bus.layer) < MAX_MATRICES)
              && (int'(in_bus.row) < MAX_NODES) && (int'(in_bus.column) < MAX_NODES);
    w_waddr = WAW'((int'(in_bus.layer) * MAX_NODES + int'(in_bus.row)) * MAX_NODES
              + int'(in_bus.column));
    b_we    = in_acc && (in_bus.mode == MODE_BIAS) && (int'(in_bus.layer) < MAX_MATRICES)
              && (int'(in_bus.row) < MAX_NODES);
    b_waddr = BAW'(int'(in_bus.layer) * MAX_NODES + int'(in_bus.row));
  end

  // read addresses follow the next column so data lines up with S_MUL
  always_comb begin
    w_raddr = WAW'((int'(m_r) * MAX_NODES + int'(r_r)) * MAX_NODES + int'(c_nxt));
    b_raddr = BAW'(int'(m_r) * MAX_NODES + int'(r_r));
    v_raddr = VAW'(src_reg * MAX_NODES + int'(c_nxt));
  end

  always_comb begin
    state_nxt     = state_r;
    m_nxt         = m_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    cur_len_nxt   = cur_len_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    out_value_nxt = out_value_r;
    out_index_nxt = out_index_r;
    out_last_nxt  = out_last_r;
    act_en        = 1'b0;
    v_we          = 1'b0;
    v_waddr       = VAW'(int'(in_bus.column));
    v_wdata       = in_bus.value;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_bus.mode == MODE_SAMPLE)) begin
          v_we = (int'(in_bus.column) < MAX_NODES);
          if (in_bus.last) begin
            m_nxt       = '0;
            r_nxt       = '0;
            c_nxt       = '0;
            cur_len_nxt = n_in;
            state_nxt   = S_ROW;
          end
        end
      end
      S_ROW: begin
        state_nxt = S_BIAS;
      end
      S_BIAS: begin
        acc_nxt   = ACC_WIDTH'($signed(b_rd)) <<< FRAC_BITS;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = $signed(w_rd) * $signed(v_rd);
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_nxt = acc_r + ACC_WIDTH'(prod_r);
        if (CW'(c_r) == cur_len_r - CW'(1)) begin
          state_nxt = S_RND;
        end else begin
          c_nxt     = c_r + NW'(1);
          state_nxt = S_MUL;
        end
      end
      S_RND: begin
        sat_nxt   = round_sat(acc_r);
        state_nxt = S_ACT;
      end
      S_ACT: begin
        act_en    = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        if (!last_mat || !out_valid_r || out_bus.ready) begin
          if (last_mat) begin
            out_valid_nxt = 1'b1;
            out_value_nxt = act_y;
            out_index_nxt = 4'(r_r);
            out_last_nxt  = (CW'(r_r) == len - CW'(1));
          end else begin
            v_we    = 1'b1;
            v_waddr = VAW'(dst_reg * MAX_NODES + int'(r_r));
            v_wdata = act_y;
          end
          c_nxt = '0;
          if (CW'(r_r) == len - CW'(1)) begin
            if (last_mat) begin
              state_nxt = S_IDLE;
            end else begin
              m_nxt       = m_r + MW'(1);
              r_nxt       = '0;
              cur_len_nxt = len;
              state_nxt   = S_ROW;
            end
          end else begin
            r_nxt     = r_r + NW'(1);
            state_nxt = S_ROW;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      m_r         <= '0;
      r_r         <= '0;
      c_r         <= '0;
      cur_len_r   <= CW'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      m_r         <= m_nxt;
      r_r         <= r_nxt;
      c_r         <= c_nxt;
      cur_len_r   <= cur_len_nxt;
    end
    acc_r       <= acc_nxt;
    prod_r      <= prod_nxt;
    sat_r       <= sat_nxt;
    out_value_r <= out_value_nxt;
    out_index_r <= out_index_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.result_value = out_value_r;
  assign out_bus.result_index = out_index_r;
  assign out_bus.result_last  = out_last_r;

  mlp_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(WDEPTH)) u_wram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(in_bus.value),
    .raddr(w_raddr), .rdata_r(w_rd)
  );

  mlp_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(BDEPTH)) u_bram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(in_bus.value),
    .raddr(b_raddr), .rdata_r(b_rd)
  );

  mlp_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(VDEPTH)) u_vram (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata_r(v_rd)
  );

  mlp_act u_act (
    .clk(clk), .en(act_en), .kind(act_kind_r), .x(sat_r), .y_r(act_y)
  );

endmodule

@@ rtl/core/mlp_chk.sv @@
module mlp_chk import mlp_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_mode,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input value_t     out_value,
  input logic [3:0] out_index,
  input logic       out_last
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_SAMPLE && in_last |=> !in_ready)
    else $error("input still ready after a pass started");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_index)
    && $stable(out_last))
    else $error("stalled result word changed");

endmodule

bind mlp_forward_inference mlp_chk u_mlp_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_bus.valid), .in_ready(in_bus.ready), .in_mode(in_bus.mode),
  .in_last(in_bus.last),
  .out_valid(out_bus.valid), .out_ready(out_bus.ready),
  .out_value(out_bus.result_value), .out_index(out_bus.result_index),
  .out_last(out_bus.result_last)
);
